### rtl/swd_pkg.sv
package swd_pkg;

    localparam logic [7:0]  RST1_LEN   = 8'd64;
    localparam logic [7:0]  SWITCH_LEN = 8'd16;
    localparam logic [7:0]  RST2_LEN   = 8'd56;
    localparam logic [7:0]  REQ_LEN    = 8'd8;
    localparam logic [7:0]  ACK_LEN    = 8'd3;
    localparam logic [7:0]  DATA_LEN   = 8'd33;
    localparam logic [15:0] SWITCH_SEQ = 16'hE79E;

    localparam logic [1:0] KIND_CLOCK   = 2'd0;
    localparam logic [1:0] KIND_XFER    = 2'd1;
    localparam logic [1:0] KIND_CONNECT = 2'd2;

    localparam logic [2:0] ACK_OK    = 3'd1;
    localparam logic [2:0] ACK_WAIT  = 3'd2;
    localparam logic [2:0] ACK_FAULT = 3'd4;

    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_PROTOCOL     = 3'd1;
    localparam logic [2:0] ST_PARITY       = 3'd2;
    localparam logic [2:0] ST_CONN_TIMEOUT = 3'd3;
    localparam logic [2:0] ST_CONN_FAULT   = 3'd4;

    localparam logic [1:0] CFG_TAIL_LEN   = 2'd0;
    localparam logic [1:0] CFG_DATA_PHASE = 2'd1;
    localparam logic [1:0] CFG_TURNAROUND = 2'd2;

    typedef enum logic [11:0] {
        PH_IDLE   = 12'b0000_0000_0001,
        PH_RST1   = 12'b0000_0000_0010,
        PH_SWITCH = 12'b0000_0000_0100,
        PH_RST2   = 12'b0000_0000_1000,
        PH_CIDLE  = 12'b0000_0001_0000,
        PH_REQ    = 12'b0000_0010_0000,
        PH_TURN1  = 12'b0000_0100_0000,
        PH_ACK    = 12'b0000_1000_0000,
        PH_RDATA  = 12'b0001_0000_0000,
        PH_TURN2  = 12'b0010_0000_0000,
        PH_WDATA  = 12'b0100_0000_0000,
        PH_TAIL   = 12'b1000_0000_0000
    } t_phase;

    typedef struct packed {
        logic [7:0] tail_len;
        logic       data_phase_on_error;
        logic [2:0] turnaround_cycles;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  kind;
        logic        access_port;
        logic        is_read;
        logic [1:0]  reg_addr;
        logic [31:0] write_data;
        logic [7:0]  retry_limit;
        logic        swdio_in;
    } t_item;

    typedef struct packed {
        logic        swdio_out;
        logic        swdio_drive;
        logic        busy_res;
        logic        done_res;
        logic [2:0]  ack_code;
        logic [2:0]  status;
        logic [31:0] read_data;
    } t_result;

    function automatic logic [7:0] encode_request(input logic ap, input logic rd,
                                                  input logic [1:0] addr);
        return {1'b1, 1'b0, ap ^ rd ^ addr[0] ^ addr[1], addr[1], addr[0], rd, ap, 1'b1};
    endfunction

    function automatic logic [7:0] turn_len(input logic [2:0] t);
        logic [7:0] len;
        if (t == 3'd0) begin
            len = 8'd1;
        end else if (t > 3'd4) begin
            len = 8'd4;
        end else begin
            len = {5'b0, t};
        end
        return len;
    endfunction

    function automatic logic ack_valid(input logic [2:0] ack);
        return (ack == ACK_OK) || (ack == ACK_WAIT) || (ack == ACK_FAULT);
    endfunction

    // PH_IDLE as a result marks the end of the operation
    function automatic t_phase following(input t_phase p, input logic [2:0] ack,
                                         input logic rd, input logic dpe);
        t_phase nxt;
        case (p)
            PH_RST1:   nxt = PH_SWITCH;
            PH_SWITCH: nxt = PH_RST2;
            PH_RST2:   nxt = PH_CIDLE;
            PH_CIDLE:  nxt = PH_REQ;
            PH_REQ:    nxt = PH_TURN1;
            PH_TURN1:  nxt = PH_ACK;
            PH_ACK: begin
                if (!ack_valid(ack)) begin
                    nxt = PH_RDATA;
                end else if (ack == ACK_OK) begin
                    nxt = rd ? PH_RDATA : PH_TURN2;
                end else begin
                    nxt = (dpe && rd) ? PH_RDATA : PH_TURN2;
                end
            end
            PH_RDATA:  nxt = PH_TURN2;
            PH_TURN2: begin
                if (!rd && ack_valid(ack) && (ack == ACK_OK || dpe)) begin
                    nxt = PH_WDATA;
                end else begin
                    nxt = PH_TAIL;
                end
            end
            PH_WDATA:  nxt = PH_TAIL;
            default:   nxt = PH_IDLE;
        endcase
        return nxt;
    endfunction

endpackage

### rtl/swd_host_transfer_engine.sv
// SWD host transfer engine; each input transaction is a SWCLK cycle on the bus.
// Input channel: i_in_valid / o_in_stall with the item fields. kind selects a
// plain clock cycle, the start of a read/write transfer or the start of a
// connect (line reset, switch sequence, line reset, idle, IDCODE read). A
// start is only honored while idle; otherwise it is a plain clock cycle.
// Output channel: o_out_valid / i_out_stall. Every input transaction yields
// exactly one output transaction with the SWDIO level and drive enable for
// that cycle, busy/done flags, the acknowledge, and status and read data in
// the cycle done is set.
// The result is registered: it is written to the output register by the edge
// that accepts the input. One transaction is taken per cycle while the output is
// not stalled; the sequencer state and the output register update in the same edge.
// When the receiver stalls, the result holds and a new input is still taken
// as long as the output register is free or being drained in that cycle.
// Configuration writes (tail idle length, dummy data phase, turnaround length)
// go through i_cfg_we / i_cfg_idx / i_cfg_data and apply at the next phase.
// Reset returns the sequencer to idle and the registers to tail idle length 0,
// no dummy data phase, turnaround length 1; no output is pending.
module swd_host_transfer_engine #(
    parameter logic [7:0] CONNECT_RETRIES = 8'd5,
    parameter logic [7:0] CONNECT_IDLE    = 8'd8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic        i_access_port,
    input  logic        i_is_read,
    input  logic [1:0]  i_reg_addr,
    input  logic [31:0] i_write_data,
    input  logic [7:0]  i_retry_limit,
    input  logic        i_swdio_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_swdio_out,
    output logic        o_swdio_drive,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic [2:0]  o_ack_code,
    output logic [2:0]  o_status,
    output logic [31:0] o_read_data
);
    import swd_pkg::*;

    t_cfg    r_cfg;
    t_item   w_item;
    t_result w_res;
    t_result r_out;
    logic    r_out_valid;
    logic    w_accept;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_item = '{kind: i_kind, access_port: i_access_port, is_read: i_is_read,
                      reg_addr: i_reg_addr, write_data: i_write_data,
                      retry_limit: i_retry_limit, swdio_in: i_swdio_in};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tail_len            <= 8'd0;
            r_cfg.data_phase_on_error <= 1'b0;
            r_cfg.turnaround_cycles   <= 3'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TAIL_LEN:   r_cfg.tail_len            <= i_cfg_data;
                CFG_DATA_PHASE: r_cfg.data_phase_on_error <= i_cfg_data[0];
                CFG_TURNAROUND: r_cfg.turnaround_cycles   <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    swd_engine #(
        .CONNECT_RETRIES(CONNECT_RETRIES),
        .CONNECT_IDLE   (CONNECT_IDLE)
    ) u_engine (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_accept),
        .i_cfg  (r_cfg),
        .i_item (w_item),
        .o_res  (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_swdio_out   = r_out.swdio_out;
    assign o_swdio_drive = r_out.swdio_drive;
    assign o_busy_res    = r_out.busy_res;
    assign o_done_res    = r_out.done_res;
    assign o_ack_code    = r_out.ack_code;
    assign o_status      = r_out.status;
    assign o_read_data   = r_out.read_data;

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_done_res |-> o_busy_res)
        else $error("done without busy");

    a_release_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_swdio_drive |-> !o_swdio_out && o_busy_res)
        else $error("released line not low or not busy");

    a_status_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_done_res |-> o_status == ST_OK && o_read_data == 32'd0)
        else $error("status or data outside done");

endmodule

### rtl/swd_engine.sv
module swd_engine #(
    parameter logic [7:0] CONNECT_RETRIES = 8'd5,
    parameter logic [7:0] CONNECT_IDLE    = 8'd8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  swd_pkg::t_cfg    i_cfg,
    input  swd_pkg::t_item   i_item,
    output swd_pkg::t_result o_res
);
    import swd_pkg::*;

    t_phase      r_phase,       n_phase;
    logic [7:0]  r_bit_count,   n_bit_count;
    logic [63:0] r_shift,       n_shift;
    logic [7:0]  r_request,     n_request;
    logic [31:0] r_pending,     n_pending;
    logic [7:0]  r_retries,     n_retries;
    logic [2:0]  r_last_ack,    n_last_ack;
    logic [32:0] r_captured,    n_captured;
    logic        r_in_connect,  n_in_connect;

    function automatic logic [7:0] phase_len(input t_phase p, input t_cfg cfg);
        logic [7:0] len;
        case (p)
            PH_RST1:   len = RST1_LEN;
            PH_SWITCH: len = SWITCH_LEN;
            PH_RST2:   len = RST2_LEN;
            PH_CIDLE:  len = CONNECT_IDLE;
            PH_REQ:    len = REQ_LEN;
            PH_TURN1:  len = turn_len(cfg.turnaround_cycles);
            PH_ACK:    len = ACK_LEN;
            PH_RDATA:  len = DATA_LEN;
            PH_TURN2:  len = turn_len(cfg.turnaround_cycles);
            PH_WDATA:  len = DATA_LEN;
            PH_TAIL:   len = cfg.tail_len;
            default:   len = 8'd0;
        endcase
        return len;
    endfunction

    function automatic logic [63:0] entry_shift(input t_phase p, input logic [7:0] req,
                                                input logic [31:0] pw,
                                                input logic [2:0] ack);
        logic [63:0] sh;
        case (p)
            PH_RST1:   sh = '1;
            PH_SWITCH: sh = {48'b0, SWITCH_SEQ};
            PH_RST2:   sh = {8'b0, {56{1'b1}}};
            PH_REQ:    sh = {56'b0, req};
            PH_WDATA:  sh = (ack == ACK_OK) ? {31'b0, ^pw, pw} : 64'b0;
            default:   sh = 64'b0;
        endcase
        return sh;
    endfunction

    always_comb begin
        t_phase nxt;
        logic   rd;
        nxt          = PH_IDLE;
        rd           = 1'b0;
        n_phase      = r_phase;
        n_bit_count  = r_bit_count;
        n_shift      = r_shift;
        n_request    = r_request;
        n_pending    = r_pending;
        n_retries    = r_retries;
        n_last_ack   = r_last_ack;
        n_captured   = r_captured;
        n_in_connect = r_in_connect;
        o_res        = '0;
        o_res.swdio_drive = 1'b1;

        if (r_phase == PH_IDLE && i_item.kind == KIND_XFER) begin
            n_in_connect = 1'b0;
            n_request    = encode_request(i_item.access_port, i_item.is_read,
                                          i_item.reg_addr);
            n_pending    = i_item.write_data;
            n_retries    = i_item.retry_limit;
            n_last_ack   = '0;
            n_phase      = PH_REQ;
            n_bit_count  = REQ_LEN;
            n_shift      = {56'b0, n_request};
        end else if (r_phase == PH_IDLE && i_item.kind == KIND_CONNECT) begin
            n_in_connect = 1'b1;
            n_request    = encode_request(1'b0, 1'b1, 2'b00);
            n_pending    = '0;
            n_retries    = CONNECT_RETRIES;
            n_last_ack   = '0;
            n_phase      = PH_RST1;
            n_bit_count  = RST1_LEN;
            n_shift      = '1;
        end

        if (n_phase != PH_IDLE) begin
            o_res.busy_res = 1'b1;
            if (n_phase inside {PH_TURN1, PH_ACK, PH_RDATA, PH_TURN2}) begin
                o_res.swdio_drive = 1'b0;
                if (n_phase == PH_ACK) begin
                    n_last_ack = {i_item.swdio_in, n_last_ack[2:1]};
                end else if (n_phase == PH_RDATA) begin
                    n_captured = {i_item.swdio_in, n_captured[32:1]};
                end
            end else begin
                o_res.swdio_out = n_shift[0];
                n_shift         = n_shift >> 1;
            end
            if (n_bit_count != 8'd0) begin
                n_bit_count = n_bit_count - 8'd1;
            end
            if (n_bit_count == 8'd0) begin
                rd  = n_request[2];
                nxt = following(n_phase, n_last_ack, rd, i_cfg.data_phase_on_error);
                if (nxt == PH_CIDLE && CONNECT_IDLE == 8'd0) begin
                    nxt = PH_REQ;
                end
                if (nxt == PH_TAIL && i_cfg.tail_len == 8'd0) begin
                    nxt = PH_IDLE;
                end
                if (nxt == PH_IDLE && n_last_ack == ACK_WAIT && n_retries != 8'd0) begin
                    n_retries = n_retries - 8'd1;
                    nxt       = PH_REQ;
                end
                if (nxt != PH_IDLE) begin
                    n_phase     = nxt;
                    n_bit_count = phase_len(nxt, i_cfg);
                    n_shift     = entry_shift(nxt, n_request, n_pending, n_last_ack);
                    if (nxt == PH_ACK) begin
                        n_last_ack = '0;
                    end
                    if (nxt == PH_RDATA) begin
                        n_captured = '0;
                    end
                end else begin
                    o_res.done_res = 1'b1;
                    if (!ack_valid(n_last_ack)) begin
                        o_res.status = ST_PROTOCOL;
                    end else if (n_last_ack == ACK_OK && rd &&
                                 n_captured[32] != ^n_captured[31:0]) begin
                        o_res.status = ST_PARITY;
                    end else if (n_in_connect && n_last_ack == ACK_WAIT) begin
                        o_res.status = ST_CONN_TIMEOUT;
                    end else if (n_in_connect && n_last_ack == ACK_FAULT) begin
                        o_res.status = ST_CONN_FAULT;
                    end
                    if (o_res.status == ST_OK && n_last_ack == ACK_OK && rd) begin
                        o_res.read_data = n_captured[31:0];
                    end
                    n_phase     = PH_IDLE;
                    n_bit_count = '0;
                    n_shift     = '0;
                end
            end
        end
        o_res.ack_code = n_last_ack;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_bit_count  <= '0;
            r_shift      <= '0;
            r_request    <= '0;
            r_pending    <= '0;
            r_retries    <= '0;
            r_last_ack   <= '0;
            r_captured   <= '0;
            r_in_connect <= 1'b0;
        end else if (i_en) begin
            r_phase      <= n_phase;
            r_bit_count  <= n_bit_count;
            r_shift      <= n_shift;
            r_request    <= n_request;
            r_pending    <= n_pending;
            r_retries    <= n_retries;
            r_last_ack   <= n_last_ack;
            r_captured   <= n_captured;
            r_in_connect <= n_in_connect;
        end
    end

endmodule
